/* rtl/ddc_pkg.sv */
// Package for the digital down converter: shared widths, register indexes,
// controller state type, command and status structs, and the constant tables.
// No dependencies; every other file in rtl/ uses it by scoped names.
`default_nettype none

package ddc_pkg;

	// Fixed field widths.
	localparam int SAMPLE_BITS    = 8;
	localparam int TRIG_BITS      = 16;
	localparam int MIX_BITS       = SAMPLE_BITS + TRIG_BITS;
	localparam int OUT_BITS       = 48;
	localparam int STEP_BITS      = 32;
	localparam int DECIM_BITS     = 6;
	localparam int CFG_DATA_BITS  = 32;
	localparam int CFG_INDEX_BITS = 2;

	// Register indexes on the configuration port.
	localparam logic [CFG_INDEX_BITS-1:0] REG_PHASE_STEP = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_DECIMATION = 2'd1;

	// Register reset values.
	localparam logic [STEP_BITS-1:0]  PHASE_STEP_RESET = 32'd206158430;
	localparam logic [DECIM_BITS-1:0] DECIMATION_RESET = 6'd20;

	// Default values for the top-level parameters.
	localparam int TAPS_DEFAULT          = 61;
	localparam int COEF_BITS_DEFAULT     = 20;
	localparam int PHASE_BITS_DEFAULT    = 32;
	localparam int LUT_ADDR_BITS_DEFAULT = 10;

	// Pi scaled by 2^30, used to build the sine table.
	localparam longint unsigned PI_Q30 = 64'd3373259426;

	// Filter coefficients, antisymmetric about the centre tap, value times 2^32.
	localparam int COEF_LEN = 61;
	localparam int COEF_ROM [COEF_LEN] = '{
		-241937, -51361, -55970, -61097, -65644, -69718, -73702, -77494,
		-80783, -83482, -85652, -87256, -88213, -88520, -88203, -87223,
		-85522, -83096, -79963, -76126, -71596, -66427, -60681, -54398,
		-47621, -40410, -32826, -24922, -16759, -8421, 0, 8421,
		16759, 24922, 32826, 40410, 47621, 54398, 60681, 66427,
		71596, 76126, 79963, 83096, 85522, 87223, 88203, 88520,
		88213, 87256, 85652, 83482, 80783, 77494, 73702, 69718,
		65644, 61097, 55970, 51361, 241937
	};

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIX,
		ST_MAC,
		ST_DRAIN,
		ST_OUT
	} ctrl_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic in_ready;
		logic mix_write;
		logic mac_start;
		logic mac_issue;
		logic out_load;
	} ddc_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic in_take;
		logic fire;
		logic last_tap;
		logic pipe_busy;
	} ddc_status_t;

	// Filter coefficient for tap i; taps past the table are zero.
	function automatic int coef_at(input int i);
		int c;
		c = 0;
		if (i < COEF_LEN) begin
			c = COEF_ROM[i];
		end
		return c;
	endfunction

	// Quarter-wave sine entry k in Q15, from an integer Taylor series in Q30.
	// Only evaluated at elaboration to fill constant tables.
	function automatic logic [TRIG_BITS-1:0] quarter_sine(input int k, input int lut_bits);
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint sum;
		longint q;
		x = (64'(k) * 64'd2 * PI_Q30) >> lut_bits;
		x2 = (x * x) >> 30;
		term = x;
		sum = longint'(x);
		for (int n = 1; n <= 8; n++) begin
			term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
			if ((n % 2) == 1) begin
				sum = sum - longint'(term);
			end else begin
				sum = sum + longint'(term);
			end
		end
		if (sum < 0) begin
			sum = 0;
		end
		q = (sum + 64'sd16384) >>> 15;
		if (q > 32767) begin
			q = 32767;
		end
		return TRIG_BITS'(q);
	endfunction

endpackage

`default_nettype wire

/* rtl/digital_down_converter_core.sv */
// Digital down converter: each 8-bit sample is mixed with an oscillator
// (32-bit phase accumulator into a 2^LUT_ADDR_BITS-point sine table) and kept
// in a TAPS-entry history; on every decimation-th sample one shared complex
// MAC runs the TAPS-tap filter, newest sample first, and emits one result.
// A sample that produces no output passes through the idle and mix states. A
// sample that produces an output also passes through the MAC, drain and output
// states, with the single MAC reading one history entry per cycle through the
// memory's one read port, and the output state waits on the output register. The
// result waits in an output register, so a new sample is taken while it is
// still pending; the next output is held back until that one is taken. The
// history reads as zero after reset, with no clearing pass.
// Depends on ddc_pkg, ddc_ctrl and ddc_datapath.
`default_nettype none

module digital_down_converter_core #(
	parameter int TAPS          = ddc_pkg::TAPS_DEFAULT,
	parameter int COEF_BITS     = ddc_pkg::COEF_BITS_DEFAULT,
	parameter int PHASE_BITS    = ddc_pkg::PHASE_BITS_DEFAULT,
	parameter int LUT_ADDR_BITS = ddc_pkg::LUT_ADDR_BITS_DEFAULT
) (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	// Input stream.
	input  wire logic                                  s_tvalid,
	output      logic                                  s_tready,
	input  wire logic [ddc_pkg::SAMPLE_BITS-1:0]       s_tdata,  // [7:0] sample
	// Output stream.
	output      logic                                  m_tvalid,
	input  wire logic                                  m_tready,
	output      logic [2*ddc_pkg::OUT_BITS-1:0]        m_tdata,  // [47:0] out_real,
	                                                            // [95:48] out_imag
	// Configuration write port.
	input  wire logic                                  cfg_we,
	input  wire logic [ddc_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
	input  wire logic [ddc_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

	// Configuration registers.
	logic [ddc_pkg::STEP_BITS-1:0]  phase_step_q;
	logic [ddc_pkg::DECIM_BITS-1:0] decimation_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_step_q <= ddc_pkg::PHASE_STEP_RESET;
			decimation_q <= ddc_pkg::DECIMATION_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ddc_pkg::REG_PHASE_STEP: phase_step_q <= cfg_data;
				ddc_pkg::REG_DECIMATION: decimation_q <= cfg_data[ddc_pkg::DECIM_BITS-1:0];
				default: ;
			endcase
		end
	end

	ddc_pkg::ddc_cmd_t    cmd;
	ddc_pkg::ddc_status_t status;
	logic                 out_free;
	logic signed [ddc_pkg::OUT_BITS-1:0] acc_re;
	logic signed [ddc_pkg::OUT_BITS-1:0] acc_im;

	ddc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.status   (status),
		.out_free (out_free),
		.cmd      (cmd)
	);

	ddc_datapath #(
		.TAPS          (TAPS),
		.COEF_BITS     (COEF_BITS),
		.PHASE_BITS    (PHASE_BITS),
		.LUT_ADDR_BITS (LUT_ADDR_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.in_valid   (s_tvalid),
		.sample     (signed'(s_tdata)),
		.phase_step (phase_step_q),
		.decimation (decimation_q),
		.status     (status),
		.acc_re     (acc_re),
		.acc_im     (acc_im)
	);

	assign s_tready = cmd.in_ready;

	// Output register: holds one result until its transaction completes.
	logic                                m_valid_q;
	logic [2*ddc_pkg::OUT_BITS-1:0]      m_data_q;

	assign out_free = !m_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			m_data_q <= {acc_im, acc_re};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_valid_q || m_tready))
		else $error("output register overwritten while pending");

	// One sample at a time: no transaction in the cycle after one.
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input accepted while previous sample in progress");

endmodule

`default_nettype wire

/* rtl/ddc_ctrl.sv */
// Controller for the digital down converter: sequences mixing, the filter
// MAC loop, pipeline drain and result hand-off. Depends on ddc_pkg.
`default_nettype none

module ddc_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire ddc_pkg::ddc_status_t status,
	input  wire logic               out_free,
	output      ddc_pkg::ddc_cmd_t  cmd
);

	ddc_pkg::ctrl_state_t state_q;
	ddc_pkg::ctrl_state_t state_next;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ddc_pkg::ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	// Next-state logic; the idle state leaves on an accepted transaction.
	always_comb begin
		state_next = state_q;
		case (state_q)
			ddc_pkg::ST_IDLE: begin
				if (status.in_take) begin
					state_next = ddc_pkg::ST_MIX;
				end
			end
			ddc_pkg::ST_MIX: begin
				state_next = status.fire ? ddc_pkg::ST_MAC : ddc_pkg::ST_IDLE;
			end
			ddc_pkg::ST_MAC: begin
				if (status.last_tap) begin
					state_next = ddc_pkg::ST_DRAIN;
				end
			end
			ddc_pkg::ST_DRAIN: begin
				if (!status.pipe_busy) begin
					state_next = ddc_pkg::ST_OUT;
				end
			end
			ddc_pkg::ST_OUT: begin
				if (out_free) begin
					state_next = ddc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_next = ddc_pkg::ST_IDLE;
			end
		endcase
	end

	// Output logic.
	always_comb begin
		cmd = '0;
		case (state_q)
			ddc_pkg::ST_IDLE: begin
				cmd.in_ready = 1'b1;
			end
			ddc_pkg::ST_MIX: begin
				cmd.mix_write = 1'b1;
				cmd.mac_start = status.fire;
			end
			ddc_pkg::ST_MAC: begin
				cmd.mac_issue = 1'b1;
			end
			ddc_pkg::ST_OUT: begin
				cmd.out_load = out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

/* rtl/ddc_datapath.sv */
// Datapath for the digital down converter: oscillator, mixer, sample history
// memory and the shared complex MAC. Depends on ddc_pkg.
`default_nettype none

module ddc_datapath #(
	parameter int TAPS          = ddc_pkg::TAPS_DEFAULT,
	parameter int COEF_BITS     = ddc_pkg::COEF_BITS_DEFAULT,
	parameter int PHASE_BITS    = ddc_pkg::PHASE_BITS_DEFAULT,
	parameter int LUT_ADDR_BITS = ddc_pkg::LUT_ADDR_BITS_DEFAULT
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire ddc_pkg::ddc_cmd_t                      cmd,
	input  wire logic                                   in_valid,
	input  wire logic signed [ddc_pkg::SAMPLE_BITS-1:0] sample,
	input  wire logic [ddc_pkg::STEP_BITS-1:0]          phase_step,
	input  wire logic [ddc_pkg::DECIM_BITS-1:0]         decimation,
	output      ddc_pkg::ddc_status_t                   status,
	output      logic signed [ddc_pkg::OUT_BITS-1:0]    acc_re,
	output      logic signed [ddc_pkg::OUT_BITS-1:0]    acc_im
);

	localparam int IDX_BITS  = (TAPS > 1) ? $clog2(TAPS) : 1;
	localparam int QUARTER   = 1 << (LUT_ADDR_BITS - 2);
	localparam int QIDX_BITS = LUT_ADDR_BITS - 1;
	localparam int MIX_BITS  = ddc_pkg::MIX_BITS;
	localparam int TRIG_BITS = ddc_pkg::TRIG_BITS;
	localparam int OUT_BITS  = ddc_pkg::OUT_BITS;
	localparam int PROD_BITS = MIX_BITS + COEF_BITS;

	// Constant tables: quarter-wave sine and filter coefficients.
	logic [TRIG_BITS-1:0]        qsin_tab [QUARTER+1];
	logic signed [COEF_BITS-1:0] coef_tab [TAPS];

	for (genvar g = 0; g <= QUARTER; g++) begin : g_qsin
		localparam logic [TRIG_BITS-1:0] QSIN_VAL = ddc_pkg::quarter_sine(g, LUT_ADDR_BITS);
		assign qsin_tab[g] = QSIN_VAL;
	end

	for (genvar g = 0; g < TAPS; g++) begin : g_coef
		assign coef_tab[g] = COEF_BITS'(ddc_pkg::coef_at(g));
	end

	logic accept;
	assign accept = cmd.in_ready && in_valid;

	// Oscillator phase and decimation counter.
	logic [PHASE_BITS-1:0]          phase_q;
	logic [ddc_pkg::DECIM_BITS-1:0] decim_q;
	logic [ddc_pkg::DECIM_BITS-1:0] decim_inc;
	logic                           fire_q;

	assign decim_inc = decim_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			decim_q <= '0;
			fire_q  <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_q + phase_step[PHASE_BITS-1:0];
			fire_q  <= (decim_inc == decimation);
			decim_q <= (decim_inc == decimation) ? '0 : decim_inc;
		end
	end

	// Sine and cosine lookups by quarter-wave symmetry.
	logic [LUT_ADDR_BITS-1:0]    sin_addr;
	logic [LUT_ADDR_BITS-1:0]    cos_addr;
	logic [QIDX_BITS-1:0]        sin_idx;
	logic [QIDX_BITS-1:0]        cos_idx;
	logic signed [TRIG_BITS-1:0] sin_val;
	logic signed [TRIG_BITS-1:0] cos_val;

	assign sin_addr = phase_q[PHASE_BITS-1 -: LUT_ADDR_BITS];
	assign cos_addr = sin_addr + LUT_ADDR_BITS'(QUARTER);

	always_comb begin
		if (sin_addr[LUT_ADDR_BITS-2]) begin
			sin_idx = QIDX_BITS'(QUARTER) - {1'b0, sin_addr[LUT_ADDR_BITS-3:0]};
		end else begin
			sin_idx = {1'b0, sin_addr[LUT_ADDR_BITS-3:0]};
		end
		if (cos_addr[LUT_ADDR_BITS-2]) begin
			cos_idx = QIDX_BITS'(QUARTER) - {1'b0, cos_addr[LUT_ADDR_BITS-3:0]};
		end else begin
			cos_idx = {1'b0, cos_addr[LUT_ADDR_BITS-3:0]};
		end
		sin_val = sin_addr[LUT_ADDR_BITS-1] ? -signed'(qsin_tab[sin_idx])
			: signed'(qsin_tab[sin_idx]);
		cos_val = cos_addr[LUT_ADDR_BITS-1] ? -signed'(qsin_tab[cos_idx])
			: signed'(qsin_tab[cos_idx]);
	end

	// Mixer operand registers, loaded on an accepted transaction.
	logic signed [ddc_pkg::SAMPLE_BITS-1:0] sample_q;
	logic signed [TRIG_BITS-1:0]            cos_q;
	logic signed [TRIG_BITS-1:0]            nsin_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= sample;
			cos_q    <= cos_val;
			nsin_q   <= -sin_val;
		end
	end

	logic signed [MIX_BITS-1:0] mix_re;
	logic signed [MIX_BITS-1:0] mix_im;

	assign mix_re = sample_q * cos_q;
	assign mix_im = sample_q * nsin_q;

	// History memory with one valid bit per entry; an entry never written
	// reads as zero.
	logic [2*MIX_BITS-1:0] hist_mem [TAPS];
	logic [TAPS-1:0]       hist_vld_q;
	logic [IDX_BITS-1:0]   wr_idx_q;
	logic [IDX_BITS-1:0]   rd_ptr_q;
	logic [IDX_BITS-1:0]   tap_q;

	always_ff @(posedge clk) begin
		if (cmd.mix_write) begin
			hist_mem[wr_idx_q] <= {mix_im, mix_re};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			wr_idx_q   <= '0;
		end else if (cmd.mix_write) begin
			hist_vld_q[wr_idx_q] <= 1'b1;
			wr_idx_q <= (wr_idx_q == IDX_BITS'(TAPS - 1)) ? '0 : wr_idx_q + 1'b1;
		end
	end

	// Read pointer walks from the newest entry backward, one tap a cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ptr_q <= '0;
			tap_q    <= '0;
		end else if (cmd.mac_start) begin
			rd_ptr_q <= wr_idx_q;
			tap_q    <= '0;
		end else if (cmd.mac_issue) begin
			rd_ptr_q <= (rd_ptr_q == '0) ? IDX_BITS'(TAPS - 1) : rd_ptr_q - 1'b1;
			tap_q    <= (tap_q == IDX_BITS'(TAPS - 1)) ? '0 : tap_q + 1'b1;
		end
	end

	// Stage 1: memory read, valid bit and coefficient.
	logic [2*MIX_BITS-1:0]       rd_data_s1;
	logic                        rd_vld_s1;
	logic signed [COEF_BITS-1:0] coef_s1;
	logic                        issue_s1;

	always_ff @(posedge clk) begin
		if (cmd.mac_issue) begin
			rd_data_s1 <= hist_mem[rd_ptr_q];
			rd_vld_s1  <= hist_vld_q[rd_ptr_q];
			coef_s1    <= coef_tab[tap_q];
		end
	end

	// Stage 2: complex product by the real coefficient.
	logic signed [MIX_BITS-1:0]  hist_re;
	logic signed [MIX_BITS-1:0]  hist_im;
	logic signed [PROD_BITS-1:0] prod_re;
	logic signed [PROD_BITS-1:0] prod_im;
	logic signed [OUT_BITS-1:0]  prod_re_s2;
	logic signed [OUT_BITS-1:0]  prod_im_s2;
	logic                        issue_s2;

	assign hist_re = rd_vld_s1 ? signed'(rd_data_s1[MIX_BITS-1:0]) : '0;
	assign hist_im = rd_vld_s1 ? signed'(rd_data_s1[2*MIX_BITS-1:MIX_BITS]) : '0;
	assign prod_re = hist_re * coef_s1;
	assign prod_im = hist_im * coef_s1;

	always_ff @(posedge clk) begin
		if (issue_s1) begin
			prod_re_s2 <= OUT_BITS'(prod_re);
			prod_im_s2 <= OUT_BITS'(prod_im);
		end
	end

	// Pipeline occupancy and accumulators; the sum is exact modulo 2^48.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_s1 <= 1'b0;
			issue_s2 <= 1'b0;
			acc_re   <= '0;
			acc_im   <= '0;
		end else begin
			issue_s1 <= cmd.mac_issue;
			issue_s2 <= issue_s1;
			if (cmd.mac_start) begin
				acc_re <= '0;
				acc_im <= '0;
			end else if (issue_s2) begin
				acc_re <= acc_re + prod_re_s2;
				acc_im <= acc_im + prod_im_s2;
			end
		end
	end

	assign status.in_take   = accept;
	assign status.fire      = fire_q;
	assign status.last_tap  = (tap_q == IDX_BITS'(TAPS - 1));
	assign status.pipe_busy = issue_s1 || issue_s2;

	// A mixed entry is marked valid right after it is written.
	a_vld_after_write: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mix_write |=> hist_vld_q[$past(wr_idx_q)])
		else $error("history entry not valid after write");

	// The counter restarts whenever a filter output is due.
	a_decim_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (decim_inc == decimation)) |=> (decim_q == '0) && fire_q)
		else $error("decimation counter did not restart");

	// A product enters the accumulator only in the cycle after stage 1 held its read.
	a_pipe_order: assert property (@(posedge clk) disable iff (!arst_n)
		issue_s2 |-> $past(issue_s1))
		else $error("MAC pipeline out of order");

	// The filter pass never starts while taps are still in flight.
	a_start_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mac_start |-> !issue_s1 && !issue_s2)
		else $error("filter pass started with taps in flight");

endmodule

`default_nettype wire
